[sv/brh_pkg.sv]
// brh_pkg: constants, edge tables and helper functions for the binned resolution histogram
// no dependencies; imported by every module of the block
package brh_pkg;

    localparam int PT_BINS       = 14;
    localparam int ETA_BINS      = 16;
    localparam int RESIDUAL_BINS = 100;

    localparam int PT_SLOTS    = PT_BINS + 2;
    localparam int ETA_SLOTS   = ETA_BINS + 2;
    localparam int RES_SLOTS   = RESIDUAL_BINS + 2;
    localparam int STORE_DEPTH = 2 * PT_SLOTS * ETA_SLOTS * RES_SLOTS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int CNT_W  = 32;
    localparam int RANGE_W = 12;
    localparam int NUM_W  = 29;
    localparam int REM_W  = 36;
    localparam int Q_W    = 7;

    localparam logic [RANGE_W-1:0] ELECTRON_RANGE_RST = 12'd750;
    localparam logic [RANGE_W-1:0] MUON_RANGE_RST     = 12'd250;

    localparam logic REG_ELECTRON_RANGE = 1'b0;
    localparam logic REG_MUON_RANGE     = 1'b1;

    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic signed [15:0] CODE_ELECTRON = 16'sd11;
    localparam logic signed [15:0] CODE_MUON     = 16'sd13;

    localparam logic [6:0] RES_UNDERFLOW = 7'd0;
    localparam logic [6:0] RES_OVERFLOW  = 7'd101;

    typedef logic [15:0] pt_edges_t [PT_BINS+1];
    typedef logic [16:0] eta_edges_t [ETA_BINS+1];

    localparam pt_edges_t PT_EDGES = '{
        16'd320, 16'd448, 16'd512, 16'd576, 16'd640, 16'd768, 16'd896, 16'd1024,
        16'd1152, 16'd1280, 16'd1600, 16'd1920, 16'd2240, 16'd2560, 16'd3200
    };

    localparam eta_edges_t ETA_EDGES = '{
        17'd0, 17'd1638, 17'd3277, 17'd4915, 17'd6554, 17'd8192, 17'd9830, 17'd11831,
        17'd12829, 17'd14746, 17'd16384, 17'd17203, 17'd18022, 17'd18842, 17'd19661,
        17'd20480, 17'd21299
    };

    // bin = number of edges at or below the value
    function automatic logic [3:0] pt_bin_of(input logic [15:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i <= PT_BINS; i++)
        begin
            n = n + {4'd0, (v >= PT_EDGES[i])};
        end
        return n[3:0];
    endfunction

    function automatic logic [4:0] eta_bin_of(input logic [16:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i <= ETA_BINS; i++)
        begin
            n = n + {4'd0, (v >= ETA_EDGES[i])};
        end
        return n;
    endfunction

    function automatic logic [ADDR_W-1:0] store_index(input logic fl, input logic [3:0] pb,
                                                      input logic [4:0] eb,
                                                      input logic [6:0] rb);
        logic [4:0]  a;
        logic [9:0]  b;
        logic [ADDR_W-1:0] c;
        a = {fl, pb};
        b = 10'(a * 10'(ETA_SLOTS)) + {5'd0, eb};
        c = ADDR_W'(b * ADDR_W'(RES_SLOTS)) + ADDR_W'(rb);
        return c;
    endfunction

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_BIN   = 7'b0000100,
        S_NUM   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_ADDR  = 7'b0100000,
        S_RMW   = 7'b1000000
    } state_t;

endpackage

[sv/binned_resolution_histogram.sv]
// binned_resolution_histogram: top level, control sequencer and bin arithmetic
// depends on brh_pkg, brh_div and brh_mem
//
// histogram of the relative pt residual of leptons, binned by flavour, true pt and |true eta|,
// with one saturating 32 bit counter per bin held in a single-port-read memory of 58752
// entries. after reset the block clears the whole store, one entry per cycle; s_axis_tready
// stays low until then, configuration writes are taken at any time. items are handled one
// at a time: every transaction goes through bin lookup, residual numerator, address and, for
// a bin that exists, memory read, write back, and the idle step that takes the next
// transaction; a fill whose residual falls inside the histogram also passes, between
// residual numerator and address, through the bit-serial divider that finds the residual bin
// (seven quotient bits and a done step). the finished result sits in an output register, so
// a new transaction is accepted while it waits to be taken; only the write-back step waits
// for that register to free up. each transaction gives exactly one result transaction.
module binned_resolution_histogram
    import brh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pass_flag, reco_valid, particle_code[15:0], true_pt[15:0], measured_pt[15:0],
    // true_eta[16:0], read_flavour, read_pt_bin[3:0], read_eta_bin[4:0],
    // read_residual_bin[6:0], zero pad
    input  logic [87:0] s_axis_tdata,
    // opcode
    input  logic        s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // count[31:0], pt_bin[3:0], eta_bin[4:0], residual_bin[6:0], filled, zero pad
    output logic [55:0] m_axis_tdata
);

    state_t state_reg, state_next;

    // configuration
    logic [RANGE_W-1:0] e_range_reg;
    logic [RANGE_W-1:0] m_range_reg;

    // captured transaction
    logic               op_reg;
    logic               pass_reg;
    logic               reco_reg;
    logic signed [15:0] code_reg;
    logic [15:0]        gen_reg;
    logic [15:0]        meas_reg;
    logic signed [16:0] eta_reg;
    logic               rfl_reg;
    logic [3:0]         rpb_reg;
    logic [4:0]         reb_reg;
    logic [6:0]         rrb_reg;

    // working values
    logic [3:0]          pb_reg;
    logic [4:0]          eb_reg;
    logic [6:0]          rb_reg;
    logic                fl_reg;
    logic                ok_reg;
    logic                hit_reg;
    logic signed [26:0]  prod_d_reg;
    logic [27:0]         prod_rg_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic [ADDR_W-1:0]   clr_reg;

    // output register
    logic               out_valid_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic [3:0]         out_pb_reg;
    logic [4:0]         out_eb_reg;
    logic [6:0]         out_rb_reg;
    logic               out_filled_reg;

    logic               in_acc;
    logic               out_free;
    logic               code_ok;
    logic               is_muon;
    logic [16:0]        aeta;
    logic signed [16:0] diff;
    logic [RANGE_W-1:0] range_sel;
    logic signed [29:0] num;
    logic [NUM_W-1:0]   den;
    logic [CNT_W-1:0]   rd_data;
    logic [CNT_W-1:0]   inc_val;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CNT_W-1:0]   mem_wdata;
    logic               mem_re;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // flavour and acceptance of a fill
    assign code_ok = (code_reg == CODE_ELECTRON) || (code_reg == -CODE_ELECTRON) ||
                     (code_reg == CODE_MUON) || (code_reg == -CODE_MUON);
    assign is_muon = (code_reg == CODE_MUON) || (code_reg == -CODE_MUON);
    assign aeta    = eta_reg[16] ? (~eta_reg + 17'd1) : eta_reg;

    // residual numerator 1000*(meas-gen) + R*gen over denominator 2*R*gen
    assign diff      = $signed({1'b0, meas_reg}) - $signed({1'b0, gen_reg});
    assign range_sel = is_muon ? m_range_reg : e_range_reg;
    assign num       = 30'(prod_d_reg) + $signed({2'b00, prod_rg_reg});
    assign den       = {prod_rg_reg, 1'b0};

    // saturating increment
    assign inc_val = (rd_data == '1) ? rd_data : rd_data + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_range_reg <= ELECTRON_RANGE_RST;
            m_range_reg <= MUON_RANGE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ELECTRON_RANGE: e_range_reg <= cfg_data;
                REG_MUON_RANGE:     m_range_reg <= cfg_data;
                default:            e_range_reg <= e_range_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == ADDR_W'(STORE_DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  if (in_acc) state_next = S_BIN;
            S_BIN:   state_next = S_NUM;
            S_NUM:
            begin
                if (op_reg == OP_FILL && ok_reg && !num[29] && den != '0 &&
                    num[NUM_W-1:0] < den)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_DIV:   if (div_rsp.done) state_next = S_ADDR;
            S_ADDR:  state_next = S_RMW;
            S_RMW:   if (out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
        end
    end

    // capture of the incoming transaction
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg   <= s_axis_tuser;
            pass_reg <= s_axis_tdata[0];
            reco_reg <= s_axis_tdata[1];
            code_reg <= s_axis_tdata[17:2];
            gen_reg  <= s_axis_tdata[33:18];
            meas_reg <= s_axis_tdata[49:34];
            eta_reg  <= s_axis_tdata[66:50];
            rfl_reg  <= s_axis_tdata[67];
            rpb_reg  <= s_axis_tdata[71:68];
            reb_reg  <= s_axis_tdata[76:72];
            rrb_reg  <= s_axis_tdata[83:77];
        end
    end

    // bins, residual terms and store address
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_BIN:
            begin
                prod_d_reg  <= 27'(diff * 27'sd1000);
                prod_rg_reg <= 28'(range_sel) * 28'(gen_reg);
                if (op_reg == OP_READ)
                begin
                    pb_reg  <= rpb_reg;
                    eb_reg  <= reb_reg;
                    fl_reg  <= rfl_reg;
                    ok_reg  <= 1'b0;
                    hit_reg <= (reb_reg < 5'(ETA_SLOTS)) && (rrb_reg < 7'(RES_SLOTS));
                end
                else
                begin
                    pb_reg  <= pt_bin_of(gen_reg);
                    eb_reg  <= eta_bin_of(aeta);
                    fl_reg  <= is_muon;
                    ok_reg  <= pass_reg && reco_reg && (gen_reg != '0) && code_ok;
                    hit_reg <= pass_reg && reco_reg && (gen_reg != '0) && code_ok;
                end
            end
            S_NUM:
            begin
                if (op_reg == OP_READ)
                begin
                    rb_reg <= rrb_reg;
                end
                else if (!ok_reg || num[29])
                begin
                    rb_reg <= RES_UNDERFLOW;
                end
                else
                begin
                    // empty interval or residual at or above +R
                    rb_reg <= RES_OVERFLOW;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    rb_reg <= div_rsp.quot + 7'd1;
                end
            end
            S_ADDR:
            begin
                idx_reg <= store_index(fl_reg, pb_reg, eb_reg, rb_reg);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign div_req.start = (state_reg == S_NUM) && (state_next == S_DIV);
    assign div_req.num   = num[NUM_W-1:0];
    assign div_req.den   = den;

    brh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // read in S_ADDR with the address computed combinationally, write back in S_RMW
    assign mem_re    = (state_reg == S_ADDR) && hit_reg;
    assign mem_we    = (state_reg == S_CLEAR) || ((state_reg == S_RMW) && ok_reg && out_free);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_reg : idx_reg;
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : inc_val;

    brh_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (store_index(fl_reg, pb_reg, eb_reg, rb_reg)),
        .rdata (rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_RMW) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_RMW) && out_free)
        begin
            out_count_reg  <= !hit_reg ? '0 : (ok_reg ? inc_val : rd_data);
            out_pb_reg     <= pb_reg;
            out_eb_reg     <= eb_reg;
            out_rb_reg     <= rb_reg;
            out_filled_reg <= ok_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_filled_reg, out_rb_reg, out_eb_reg, out_pb_reg,
                            out_count_reg};

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("transaction accepted during store clear");

    a_div_only_from_num: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (state_reg == S_DIV))
        else $error("divider started outside residual step");

    a_write_only_rmw_or_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_CLEAR) || (state_reg == S_RMW)))
        else $error("store written outside write-back");

    a_fill_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RMW && ok_reg) |-> (rb_reg <= RES_OVERFLOW))
        else $error("residual bin beyond overflow on fill");

    a_result_after_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RMW))
        else $error("result raised without write-back step");
`endif

endmodule

[sv/brh_div.sv]
// brh_div: bit-serial restoring divider, floor(100 * num / den) for num < den
// depends on brh_pkg
module brh_div
    import brh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic [2:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'(Q_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            // 100 * num as shifts and adds
            rem_reg <= (REM_W'(req.num) << 6) + (REM_W'(req.num) << 5) + (REM_W'(req.num) << 2);
            dsh_reg <= REM_W'(req.den) << (Q_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

[sv/brh_mem.sv]
// brh_mem: counter store, one write port and one registered read port
// depends on brh_pkg
module brh_mem
    import brh_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CNT_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CNT_W-1:0]  rdata
);

    logic [CNT_W-1:0] mem [STORE_DEPTH];
    logic [CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[bench/binned_resolution_histogram_tb.sv]
// binned_resolution_histogram_tb: self-checking testbench for the binned resolution histogram
// depends on brh_pkg and binned_resolution_histogram; predicts every result transaction itself
module binned_resolution_histogram_tb;
    import brh_pkg::*;

    typedef struct {
        logic               op;
        logic               pass_flag;
        logic               reco_valid;
        logic signed [15:0] code;
        logic [15:0]        gen_pt;
        logic [15:0]        meas_pt;
        logic signed [16:0] gen_eta;
        logic               rd_flavour;
        logic [3:0]         rd_pt;
        logic [4:0]         rd_eta;
        logic [6:0]         rd_res;
    } lepton_item_t;

    typedef struct {
        logic [31:0] count;
        logic [3:0]  pt_bin;
        logic [4:0]  eta_bin;
        logic [6:0]  res_bin;
        logic        filled;
    } bin_result_t;

    localparam int NPT  = 14;
    localparam int NETA = 16;
    localparam int NRES = 100;

    localparam int PT_EDGE_TAB [NPT+1] = '{320, 448, 512, 576, 640, 768, 896, 1024, 1152,
                                            1280, 1600, 1920, 2240, 2560, 3200};
    localparam int ETA_EDGE_TAB [NETA+1] = '{0, 1638, 3277, 4915, 6554, 8192, 9830, 11831,
                                              12829, 14746, 16384, 17203, 18022, 18842,
                                              19661, 20480, 21299};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_addr;
    logic [11:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    // predictor state: shadow of the count store and of the range registers
    logic [31:0] shadow_counts [int];
    logic [11:0] electron_range;
    logic [11:0] muon_range;
    bin_result_t expected_bins [$];
    int          filled_keys [$];

    int  mismatches;
    int  hold_cycles;
    bit  steady_flow;

    binned_resolution_histogram DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // upper-bound search over an edge table: the bin is how many edges lie at or below v
    function automatic int pt_slot(input int v);
        int k;
        k = 0;
        while (k <= NPT && v >= PT_EDGE_TAB[k])
            k++;
        return k;
    endfunction

    function automatic int eta_slot(input int v);
        int k;
        k = 0;
        while (k <= NETA && v >= ETA_EDGE_TAB[k])
            k++;
        return k;
    endfunction

    function automatic int residual_slot(input int meas, input int gen, input int range_m);
        longint num;
        longint den;
        longint k;
        num = 1000 * (longint'(meas) - longint'(gen)) + longint'(range_m) * gen;
        den = 2 * longint'(range_m) * gen;
        if (num < 0)
            return 0;
        if (den == 0)
            return NRES + 1;
        k = (num * NRES) / den;
        return (k >= NRES) ? NRES + 1 : int'(k) + 1;
    endfunction

    function automatic int bin_key(input int fl, input int pb, input int eb, input int rb);
        return ((fl * 16 + pb) * 18 + eb) * 102 + rb;
    endfunction

    // works out the result of one accepted transaction and updates the shadow store
    function automatic bin_result_t histogram_outcome(input lepton_item_t it);
        bin_result_t r;
        int          abs_eta;
        int          abs_code;
        int          fl;
        int          key;
        r = '{count: '0, pt_bin: '0, eta_bin: '0, res_bin: '0, filled: 1'b0};
        if (it.op == OP_READ)
        begin
            r.pt_bin  = it.rd_pt;
            r.eta_bin = it.rd_eta;
            r.res_bin = it.rd_res;
            key = bin_key(it.rd_flavour, it.rd_pt, it.rd_eta, it.rd_res);
            if (it.rd_eta < 18 && it.rd_res < 102 && shadow_counts.exists(key))
                r.count = shadow_counts[key];
        end
        else
        begin
            abs_eta  = (it.gen_eta < 0) ? -int'(it.gen_eta) : int'(it.gen_eta);
            abs_code = (it.code < 0) ? -int'(it.code) : int'(it.code);
            r.pt_bin  = 4'(pt_slot(it.gen_pt));
            r.eta_bin = 5'(eta_slot(abs_eta));
            if (it.pass_flag && it.reco_valid && it.gen_pt != 0
                && (abs_code == 11 || abs_code == 13))
            begin
                fl = (abs_code == 13);
                r.res_bin = 7'(residual_slot(it.meas_pt, it.gen_pt,
                                             fl ? muon_range : electron_range));
                key = bin_key(fl, r.pt_bin, r.eta_bin, r.res_bin);
                if (!shadow_counts.exists(key))
                begin
                    shadow_counts[key] = '0;
                    filled_keys.push_back(key);
                end
                if (shadow_counts[key] != 32'hFFFF_FFFF)
                    shadow_counts[key] = shadow_counts[key] + 1;
                r.count  = shadow_counts[key];
                r.filled = 1'b1;
            end
        end
        return r;
    endfunction

    // sends one item; tvalid is left high so back-to-back transactions need no re-raise
    task automatic send_item(input lepton_item_t it);
        int gap;
        gap = 0;
        if (!steady_flow)
        begin
            if ($urandom_range(0, 99) < 30)
                gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {4'd0, it.rd_res, it.rd_eta, it.rd_pt, it.rd_flavour, it.gen_eta,
                          it.meas_pt, it.gen_pt, it.code, it.reco_valid, it.pass_flag};
        // ready is only changed at a rising edge, so its value at the falling edge holds
        forever
        begin
            @(negedge clk);
            if (s_axis_tready)
                break;
        end
        expected_bins.push_back(histogram_outcome(it));
        @(posedge clk);
    endtask

    // register writes only once the block is idle
    task automatic write_range(input logic idx, input logic [11:0] value);
        wait_drained();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ELECTRON_RANGE)
            electron_range = value;
        else
            muon_range = value;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic lepton_item_t fill_item(input int code, input int gen, input int meas,
                                               input int eta);
        lepton_item_t it;
        it = '{op: OP_FILL, pass_flag: 1'b1, reco_valid: 1'b1, code: 16'(code),
               gen_pt: 16'(gen), meas_pt: 16'(meas), gen_eta: 17'(eta),
               rd_flavour: 1'b0, rd_pt: '0, rd_eta: '0, rd_res: '0};
        return it;
    endfunction

    function automatic lepton_item_t read_item(input int fl, input int pb, input int eb,
                                               input int rb);
        lepton_item_t it;
        it = fill_item(0, 0, 0, 0);
        it.op = OP_READ;
        it.rd_flavour = 1'(fl);
        it.rd_pt  = 4'(pb);
        it.rd_eta = 5'(eb);
        it.rd_res = 7'(rb);
        return it;
    endfunction

    // well-formed lepton with measured pt near the true pt, random everything else
    function automatic lepton_item_t random_lepton();
        lepton_item_t it;
        int gen;
        int spread;
        int meas;
        case ($urandom_range(0, 3))
            0: gen = $urandom_range(1, 400);
            1: gen = $urandom_range(300, 3400);
            2: gen = PT_EDGE_TAB[$urandom_range(0, NPT)] - $urandom_range(0, 1);
            default: gen = $urandom_range(1, 65535);
        endcase
        spread = gen / ($urandom_range(0, 1) ? 2 : 8) + 1;
        meas = gen + $urandom_range(0, 2 * spread) - spread;
        if (meas < 0) meas = 0;
        if (meas > 65535) meas = 65535;
        it = fill_item(($urandom_range(0, 1) ? 11 : 13) * ($urandom_range(0, 1) ? 1 : -1),
                       gen, meas, 0);
        if ($urandom_range(0, 3) == 0)
            it.gen_eta = 17'($urandom());
        else
            it.gen_eta = 17'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 22000)));
        return it;
    endfunction

    function automatic lepton_item_t random_item();
        lepton_item_t it;
        int k;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            it = random_lepton();
        else if (sel < 80 && filled_keys.size() > 0)
        begin
            // read back a bin that holds something
            k  = filled_keys[$urandom_range(0, filled_keys.size() - 1)];
            it = read_item(k / (16 * 18 * 102), (k / (18 * 102)) % 16, (k / 102) % 18,
                           k % 102);
        end
        else if (sel < 90)
        begin
            it = random_lepton();
            case ($urandom_range(0, 3))
                0: it.pass_flag  = 1'b0;
                1: it.reco_valid = 1'b0;
                2: it.code       = 16'($urandom());
                default: it.gen_pt = '0;
            endcase
        end
        else
        begin
            // pure noise on every field
            it = '{op: 1'($urandom()), pass_flag: 1'($urandom()), reco_valid: 1'($urandom()),
                   code: 16'($urandom()), gen_pt: 16'($urandom()), meas_pt: 16'($urandom()),
                   gen_eta: 17'($urandom()), rd_flavour: 1'($urandom()),
                   rd_pt: 4'($urandom()), rd_eta: 5'($urandom()), rd_res: 7'($urandom())};
        end
        return it;
    endfunction

    // extremes, rejections, edge values and out-of-range reads
    task automatic test_directed();
        lepton_item_t it;
        send_item(fill_item(11, 640, 640, 0));
        send_item(fill_item(11, 640, 640, 0));
        send_item(read_item(0, 5, 1, 51));
        send_item(fill_item(-13, 320, 330, -1638));
        send_item(fill_item(13, 319, 0, 65535));
        send_item(fill_item(-11, 3200, 65535, -65536));
        send_item(fill_item(11, 65535, 65535, 21299));
        send_item(fill_item(13, 1, 65535, 21298));
        send_item(fill_item(11, 0, 100, 100));        // zero true pt
        send_item(fill_item(12, 700, 700, 100));      // unknown particle
        send_item(fill_item(-32768, 700, 700, 100));
        send_item(fill_item(32767, 700, 700, 100));
        it = fill_item(11, 700, 700, 100);
        it.pass_flag = 1'b0;
        send_item(it);
        it = fill_item(13, 700, 700, 100);
        it.reco_valid = 1'b0;
        send_item(it);
        send_item(fill_item(11, 1000, 250, 11831));   // exactly at the lower range edge
        send_item(fill_item(11, 1000, 1749, 12829));  // just below the upper edge
        send_item(fill_item(11, 1000, 1750, 12829));  // at the upper edge
        send_item(read_item(1, 15, 31, 127));         // beyond the last bin
        send_item(read_item(0, 0, 17, 102));
        send_item(read_item(1, 15, 17, 101));
        send_item(read_item(0, 7, 10, 0));
    endtask

    // several register settings, the extremes and an empty range among them
    task automatic test_range_settings();
        logic [11:0] settings [6] = '{12'd0, 12'd1, 12'd4095, 12'd4000, 12'd1000, 12'd37};
        for (int s = 0; s < 6; s++)
        begin
            write_range(REG_ELECTRON_RANGE, settings[s]);
            write_range(REG_MUON_RANGE, settings[5 - s]);
            send_item(fill_item(11, 640, 600, 0));
            send_item(fill_item(11, 640, 640, 0));
            send_item(fill_item(-13, 640, 639, 0));
            send_item(fill_item(13, 640, 641, 0));
            for (int n = 0; n < 40; n++)
                send_item(random_item());
        end
        write_range(REG_ELECTRON_RANGE, 12'd750);
        write_range(REG_MUON_RANGE, 12'd250);
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int n = 0; n < n_items; n++)
        begin
            if (n == n_items / 2)
                steady_flow = 1'b1;
            if (n == n_items / 2 + 150)
                steady_flow = 1'b0;
            send_item(random_item());
        end
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        steady_flow = 1'b1;
        hold_cycles = 400;
        for (int n = 0; n < 30; n++)
            send_item(random_lepton());
        steady_flow = 1'b0;
    endtask

    // result side ready pattern, with a long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (!steady_flow && $urandom_range(0, 99) < 25)
            begin
                stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // result checker: a transaction completes at the edge following a falling edge with both high
    initial
    begin
        bin_result_t exp_r;
        bin_result_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.count   = m_axis_tdata[31:0];
                got.pt_bin  = m_axis_tdata[35:32];
                got.eta_bin = m_axis_tdata[40:36];
                got.res_bin = m_axis_tdata[47:41];
                got.filled  = m_axis_tdata[48];
                if (expected_bins.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %h", m_axis_tdata);
                end
                else
                begin
                    exp_r = expected_bins.pop_front();
                    if (got.count !== exp_r.count || got.pt_bin !== exp_r.pt_bin
                        || got.eta_bin !== exp_r.eta_bin || got.res_bin !== exp_r.res_bin
                        || got.filled !== exp_r.filled)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: exp count %0d pt %0d eta %0d res %0d fill %0b",
                                     exp_r.count, exp_r.pt_bin, exp_r.eta_bin, exp_r.res_bin,
                                     exp_r.filled);
                            $display("          got count %0d pt %0d eta %0d res %0d fill %0b",
                                     got.count, got.pt_bin, got.eta_bin, got.res_bin,
                                     got.filled);
                        end
                    end
                end
            end
        end
    end

    // overall limit, well above the clearing pass plus the slowest run
    initial
    begin
        #12_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        mismatches     = 0;
        hold_cycles    = 0;
        steady_flow    = 1'b0;
        electron_range = ELECTRON_RANGE_RST;
        muon_range     = MUON_RANGE_RST;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = 1'b0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the store clearing pass is covered by the handshake wait in the first send
        test_directed();
        test_backpressure();
        test_range_settings();
        test_random_traffic(1300);

        wait_drained();
        if (mismatches == 0 && expected_bins.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
sv/brh_pkg.sv
sv/brh_div.sv
sv/brh_mem.sv
sv/binned_resolution_histogram.sv
bench/binned_resolution_histogram_tb.sv
